FILE: rtl/core/cpca_pkg.sv
// Package with status codes, register indexes and fixed widths for the polygon checker.
`default_nettype none

package cpca_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_CONVEX     = 2'd0,
        ST_NOT_CONVEX = 2'd1,
        ST_BAD_COUNT  = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MIN_COUNT = 2'd0,
        CFG_MAX_COUNT = 2'd1
    } t_cfg_index;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int AREA_W    = 40;

    localparam logic [CFG_W-1:0] MIN_COUNT_RESET = 8'd4;
    localparam logic [CFG_W-1:0] MAX_COUNT_RESET = 8'd7;

endpackage

`default_nettype wire

FILE: rtl/core/convex_polygon_check_area_top.sv
// Streaming polygon convexity test with twice-area accumulation.
//
// Usage: vertices enter on the input channel (i_valid / o_stall) in boundary
// order, one item per vertex, with i_is_last set on the final vertex. Only
// the final vertex produces a result item on the output channel
// (o_valid / i_stall): a status (convex, not convex, or vertex count below
// three or outside [min_count, max_count]) and twice the area when convex, else zero.
// Configuration registers are written through i_cfg_valid / o_cfg_ready,
// which is always ready; write them only while no polygon is in flight.
//
// Throughput: one vertex per cycle unless o_stall is raised. The path from
// an accepted vertex to its result is a difference stage, a multiplier
// stage (eight products), a cross product stage, a magnitude and sign
// stage, and the accumulator feeding the output register. Non-final
// vertices never wait for the output register, so the input keeps
// flowing while a result waits, until a final vertex reaches the
// accumulator with the output still occupied.
//
// Reset (synchronous, active low) empties the pipeline, clears the
// per-polygon state and loads min_count = 4 and max_count = 7.
`default_nettype none

module convex_polygon_check_area_top #(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    // Vertex input channel.
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_coord_x,
    input  wire logic signed [COORD_BITS-1:0] i_coord_y,
    input  wire logic                         i_is_last,

    // Result output channel.
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_status,
    output logic [cpca_pkg::AREA_W-1:0]       o_area_twice,

    // Configuration write channel.
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [cpca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cpca_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int CW     = COORD_BITS;
    localparam int DW     = CW + 1;
    localparam int PW     = 2 * DW;
    localparam int XW     = PW + 1;
    localparam int AW     = cpca_pkg::AREA_W;
    localparam int SUM_W  = ((XW > AW) ? XW : AW) + 1;
    localparam int CMP_W  = (COUNT_BITS > cpca_pkg::CFG_W) ? COUNT_BITS : cpca_pkg::CFG_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_W-1:0]      AREA_MAX  = {{(SUM_W-AW){1'b0}}, {AW{1'b1}}};

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [cpca_pkg::CFG_W-1:0] r_min_count;
    logic [cpca_pkg::CFG_W-1:0] r_max_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count <= cpca_pkg::MIN_COUNT_RESET;
            r_max_count <= cpca_pkg::MAX_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cpca_pkg::CFG_MIN_COUNT: r_min_count <= i_cfg_data;
                cpca_pkg::CFG_MAX_COUNT: r_max_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next one has room.
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic r_s4_last;
    logic r_out_valid;
    logic rdy_out, rdy4, rdy3, rdy2, rdy1;
    logic in_acc;

    assign rdy_out = !r_out_valid || !i_stall;
    assign rdy4    = !r_s4_valid || !r_s4_last || rdy_out;
    assign rdy3    = !r_s3_valid || rdy4;
    assign rdy2    = !r_s2_valid || rdy3;
    assign rdy1    = !r_s1_valid || rdy2;
    assign o_stall = !rdy1;
    assign in_acc  = i_valid && rdy1;

    // ------------------------------------------------------------------
    // Vertex history and vertex count, updated when an item is accepted.
    // ------------------------------------------------------------------
    logic signed [CW-1:0]   r_first_x, r_first_y;
    logic signed [CW-1:0]   r_second_x, r_second_y;
    logic signed [CW-1:0]   r_prev_x, r_prev_y;
    logic signed [CW-1:0]   r_pp_x, r_pp_y;
    logic [COUNT_BITS-1:0]  r_count;
    logic [COUNT_BITS-1:0]  n_count;

    // Count including the vertex now arriving, saturating at the top.
    assign n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            r_count <= i_is_last ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_count == '0) begin
                r_first_x <= i_coord_x;
                r_first_y <= i_coord_y;
            end
            if (r_count == COUNT_BITS'(1)) begin
                r_second_x <= i_coord_x;
                r_second_y <= i_coord_y;
            end
            r_pp_x   <= r_prev_x;
            r_pp_y   <= r_prev_y;
            r_prev_x <= i_coord_x;
            r_prev_y <= i_coord_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: edge differences and per-item flags.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] ex_vx, ex_vy, ex_px, ex_py, ex_qx, ex_qy;
    logic signed [DW-1:0] ex_fx, ex_fy, ex_sx, ex_sy;
    logic [CMP_W-1:0]     cmp_n, cmp_min, cmp_max;
    logic                 count_bad;

    assign ex_vx = {i_coord_x[CW-1], i_coord_x};
    assign ex_vy = {i_coord_y[CW-1], i_coord_y};
    assign ex_px = {r_prev_x[CW-1], r_prev_x};
    assign ex_py = {r_prev_y[CW-1], r_prev_y};
    assign ex_qx = {r_pp_x[CW-1], r_pp_x};
    assign ex_qy = {r_pp_y[CW-1], r_pp_y};
    assign ex_fx = {r_first_x[CW-1], r_first_x};
    assign ex_fy = {r_first_y[CW-1], r_first_y};
    assign ex_sx = {r_second_x[CW-1], r_second_x};
    assign ex_sy = {r_second_y[CW-1], r_second_y};

    assign cmp_n     = CMP_W'(n_count);
    assign cmp_min   = CMP_W'(r_min_count);
    assign cmp_max   = CMP_W'(r_max_count);
    assign count_bad = (cmp_n < CMP_W'(3)) || (cmp_n < cmp_min) || (cmp_n > cmp_max);

    logic signed [DW-1:0] r_ux, r_uy, r_vx, r_vy, r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0] r_wx, r_wy, r_sx, r_sy;
    logic                 r_s1_turn, r_s1_first, r_s1_last, r_s1_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rdy1) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            // Edges into and out of the previous vertex.
            r_ux <= ex_px - ex_qx;
            r_uy <= ex_py - ex_qy;
            r_vx <= ex_vx - ex_px;
            r_vy <= ex_vy - ex_py;
            // Fan triangle around the first vertex.
            r_ax <= ex_px - ex_fx;
            r_ay <= ex_py - ex_fy;
            r_bx <= ex_vx - ex_fx;
            r_by <= ex_vy - ex_fy;
            // Closing edge and the edge leaving the first vertex.
            r_wx <= ex_fx - ex_vx;
            r_wy <= ex_fy - ex_vy;
            r_sx <= ex_sx - ex_fx;
            r_sy <= ex_sy - ex_fy;
            r_s1_turn  <= (r_count >= COUNT_BITS'(2));
            r_s1_first <= (r_count == COUNT_BITS'(2));
            r_s1_last  <= i_is_last;
            r_s1_bad   <= count_bad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the eight products.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_p_t0, r_p_t1, r_p_f0, r_p_f1;
    logic signed [PW-1:0] r_p_c0, r_p_c1, r_p_d0, r_p_d1;
    logic                 r_s2_turn, r_s2_first, r_s2_last, r_s2_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_s1_valid) begin
            r_p_t0 <= r_ux * r_vy;
            r_p_t1 <= r_vx * r_uy;
            r_p_f0 <= r_ax * r_by;
            r_p_f1 <= r_bx * r_ay;
            r_p_c0 <= r_vx * r_wy;
            r_p_c1 <= r_wx * r_vy;
            r_p_d0 <= r_wx * r_sy;
            r_p_d1 <= r_sx * r_wy;
            r_s2_turn  <= r_s1_turn;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_bad   <= r_s1_bad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] r_x_turn, r_x_fan, r_x_close, r_x_wrap;
    logic                 r_s3_turn, r_s3_first, r_s3_last, r_s3_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (rdy3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid) begin
            r_x_turn  <= XW'(r_p_t0) - XW'(r_p_t1);
            r_x_fan   <= XW'(r_p_f0) - XW'(r_p_f1);
            r_x_close <= XW'(r_p_c0) - XW'(r_p_c1);
            r_x_wrap  <= XW'(r_p_d0) - XW'(r_p_d1);
            r_s3_turn  <= r_s2_turn;
            r_s3_first <= r_s2_first;
            r_s3_last  <= r_s2_last;
            r_s3_bad   <= r_s2_bad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: fan magnitude and turn classification.
    // ------------------------------------------------------------------
    logic [XW-1:0] fan_mag;
    logic [XW-1:0] r_mag;
    logic          r_t_zero, r_t_neg, r_c_zero, r_c_neg, r_w_zero, r_w_neg;
    logic          r_s4_turn, r_s4_first, r_s4_bad;

    assign fan_mag = r_x_fan[XW-1] ? XW'(-r_x_fan) : XW'(r_x_fan);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (rdy4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_s3_valid) begin
            r_mag      <= fan_mag;
            r_t_zero   <= (r_x_turn == '0);
            r_t_neg    <= r_x_turn[XW-1];
            r_c_zero   <= (r_x_close == '0);
            r_c_neg    <= r_x_close[XW-1];
            r_w_zero   <= (r_x_wrap == '0);
            r_w_neg    <= r_x_wrap[XW-1];
            r_s4_turn  <= r_s3_turn;
            r_s4_first <= r_s3_first;
            r_s4_last  <= r_s3_last;
            r_s4_bad   <= r_s3_bad;
        end
    end

    // ------------------------------------------------------------------
    // Accumulator: turn sign, failure flag and saturating area sum.
    // ------------------------------------------------------------------
    logic [AW-1:0]    r_area;
    logic             r_sign;
    logic             r_fail;
    logic             s4_take;
    logic             sign_now, fail_now, fail_fin;
    logic [SUM_W-1:0] area_sum;
    logic [AW-1:0]    area_now;
    cpca_pkg::t_status res_status;
    logic [AW-1:0]    res_area;

    assign s4_take  = r_s4_valid && rdy4;
    assign area_sum = SUM_W'(r_area) + SUM_W'(r_mag);

    always_comb begin
        sign_now = r_sign;
        fail_now = r_fail;
        area_now = r_area;
        if (r_s4_turn) begin
            if (r_t_zero) begin
                fail_now = 1'b1;
            end else if (r_s4_first) begin
                sign_now = r_t_neg;
            end else if (r_t_neg != r_sign) begin
                fail_now = 1'b1;
            end
            area_now = (area_sum > AREA_MAX) ? AREA_MAX[AW-1:0] : area_sum[AW-1:0];
        end
        // Closing turns at the last vertex and at the first vertex.
        fail_fin = fail_now || r_c_zero || (r_c_neg != sign_now)
                   || r_w_zero || (r_w_neg != sign_now);
        if (r_s4_bad) begin
            res_status = cpca_pkg::ST_BAD_COUNT;
            res_area   = '0;
        end else if (fail_fin) begin
            res_status = cpca_pkg::ST_NOT_CONVEX;
            res_area   = '0;
        end else begin
            res_status = cpca_pkg::ST_CONVEX;
            res_area   = area_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= '0;
            r_sign <= 1'b0;
            r_fail <= 1'b0;
        end else if (s4_take) begin
            if (r_s4_last) begin
                r_area <= '0;
                r_sign <= 1'b0;
                r_fail <= 1'b0;
            end else begin
                r_area <= area_now;
                r_sign <= sign_now;
                r_fail <= fail_now;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    cpca_pkg::t_status r_status;
    logic [AW-1:0]     r_area_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s4_take && r_s4_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_take && r_s4_last) begin
            r_status   <= res_status;
            r_area_out <= res_area;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_area_twice = r_area_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_area_only_convex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != cpca_pkg::ST_CONVEX)) |-> (r_area_out == '0))
        else $error("area given for a polygon that is not convex");

    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_is_last) |=> (r_count == '0))
        else $error("vertex count not cleared after the last vertex");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s4_valid && r_s4_last))
        else $error("result produced without a last vertex");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_s4_valid
                     && r_s4_last && r_out_valid))
        else $error("input stalled with room in the pipeline");

    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s4_take && r_s4_last) |=> (r_area == '0 && !r_fail && !r_sign))
        else $error("polygon state not cleared after a result");

endmodule

`default_nettype wire

FILE: test/convex_polygon_check_area_top_test.sv
// Self-checking testbench for the streaming polygon convexity and twice-area checker.
`default_nettype none

module convex_polygon_check_area_top_test;

    localparam int COORD_W        = 16;
    localparam int HOLD_CYCLES    = 90;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 12;
    localparam int PHASE_COUNT    = 8;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam real TWO_PI        = 6.283185307179586;

    localparam logic [7:0]                  COUNT_MAX = 8'hFF;
    localparam logic [cpca_pkg::AREA_W-1:0] AREA_MAX  = '1;

    // Indexes that decode to no register.
    localparam logic [cpca_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [cpca_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_vertex;

    typedef struct packed {
        cpca_pkg::t_status           status;
        logic [cpca_pkg::AREA_W-1:0] area;
    } t_verdict;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic signed [COORD_W-1:0]         i_coord_x;
    logic signed [COORD_W-1:0]         i_coord_y;
    logic                              i_is_last;
    logic                              o_valid;
    logic                              i_stall;
    logic [1:0]                        o_status;
    logic [cpca_pkg::AREA_W-1:0]       o_area_twice;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [cpca_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [cpca_pkg::CFG_W-1:0]        i_cfg_data;

    // Predicted polygon state and register copies.
    t_vertex                      poly_first;
    t_vertex                      poly_second;
    t_vertex                      poly_prev;
    t_vertex                      poly_prev2;
    logic [7:0]                   poly_count;
    logic                         poly_turn_neg;
    logic                         poly_failed;
    logic [cpca_pkg::AREA_W-1:0]  poly_area;
    logic [cpca_pkg::CFG_W-1:0]   min_count_reg;
    logic [cpca_pkg::CFG_W-1:0]   max_count_reg;

    t_verdict pending_verdicts[$];
    t_vertex  outline[$];
    int       error_count;
    int       phase_vertices;
    bit       hold_req;
    bit       quiet_idle;

    convex_polygon_check_area_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_is_last    (i_is_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_area_twice (o_area_twice),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones, none while a quiet stretch runs.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_idle || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic longint coord(logic [COORD_W-1:0] c);
        return longint'($signed(c));
    endfunction

    // Cross product of (b - a) and (c - b): the turn at b.
    function automatic longint corner_turn(t_vertex a, t_vertex b, t_vertex c);
        longint ux, uy, vx, vy;
        ux = coord(b.x) - coord(a.x);
        uy = coord(b.y) - coord(a.y);
        vx = coord(c.x) - coord(b.x);
        vy = coord(c.y) - coord(b.y);
        return ux * vy - vx * uy;
    endfunction

    // A zero turn, or one against the opening turn, breaks convexity.
    function automatic void note_turn(longint t, bit opening);
        if (t == 0) poly_failed = 1'b1;
        else if (opening) poly_turn_neg = (t < 0);
        else if ((t < 0) != poly_turn_neg) poly_failed = 1'b1;
    endfunction

    function automatic void clear_polygon();
        poly_first    = '0;
        poly_second   = '0;
        poly_prev     = '0;
        poly_prev2    = '0;
        poly_count    = '0;
        poly_turn_neg = 1'b0;
        poly_failed   = 1'b0;
        poly_area     = '0;
    endfunction

    // Advance the predicted state by one accepted vertex; a final vertex yields a verdict.
    function automatic void predict_vertex(t_vertex v, bit last);
        longint   fan, mag;
        t_verdict verdict;
        if (poly_count == 0) begin
            poly_first = v;
        end else if (poly_count == 1) begin
            poly_second = v;
        end else begin
            fan = (coord(poly_prev.x) - coord(poly_first.x)) * (coord(v.y) - coord(poly_first.y))
                - (coord(v.x) - coord(poly_first.x)) * (coord(poly_prev.y) - coord(poly_first.y));
            mag = (fan < 0) ? -fan : fan;
            note_turn(corner_turn(poly_prev2, poly_prev, v), poly_count == 2);
            if (mag > longint'(AREA_MAX) - longint'(poly_area)) poly_area = AREA_MAX;
            else poly_area = poly_area + mag[cpca_pkg::AREA_W-1:0];
        end
        poly_prev2 = poly_prev;
        poly_prev  = v;
        if (poly_count != COUNT_MAX) poly_count = poly_count + 8'd1;

        if (last) begin
            verdict.area = '0;
            if (poly_count < 3 || poly_count < min_count_reg || poly_count > max_count_reg) begin
                verdict.status = cpca_pkg::ST_BAD_COUNT;
            end else begin
                // Wrap-around corners: at the last vertex, then at vertex 0.
                note_turn(corner_turn(poly_prev2, v, poly_first), 1'b0);
                note_turn(corner_turn(v, poly_first, poly_second), 1'b0);
                if (poly_failed) begin
                    verdict.status = cpca_pkg::ST_NOT_CONVEX;
                end else begin
                    verdict.status = cpca_pkg::ST_CONVEX;
                    verdict.area   = poly_area;
                end
            end
            pending_verdicts.push_back(verdict);
            clear_polygon();
        end
    endfunction

    task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
        $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
        error_count++;
    endtask

    // Receiver: random stalls, or a long hold-off on request.
    initial begin
        int stall_left;
        int free_left;
        int held;
        i_stall    = 1'b0;
        stall_left = 0;
        free_left  = 0;
        held       = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_req = 1'b0;
                    held     = 0;
                end
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (free_left > 0) begin
                    free_left--;
                end else begin
                    stall_left = pick_gap();
                    free_left  = $urandom_range(0, 10);
                end
            end
        end
    end

    // Compare each accepted result item with the oldest predicted verdict.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result status", 0, o_status);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_status !== want.status) report_mismatch("status", want.status, o_status);
                if (o_area_twice !== want.area)
                    report_mismatch("area_twice", want.area, o_area_twice);
            end
        end
    end

    // Offer one vertex after a random gap and wait until it is taken.
    task automatic send_vertex(t_vertex v, bit last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_coord_x <= v.x;
        i_coord_y <= v.y;
        i_is_last <= last;
        do @(posedge i_clk); while (o_stall);
        predict_vertex(v, last);
        phase_vertices++;
    endtask

    task automatic add_point(int x, int y);
        t_vertex v;
        v.x = x[COORD_W-1:0];
        v.y = y[COORD_W-1:0];
        outline.push_back(v);
    endtask

    // Send the queued outline as one polygon, marking its final vertex.
    task automatic send_outline();
        foreach (outline[i]) send_vertex(outline[i], i == outline.size() - 1);
        outline.delete();
    endtask

    // Stop offering items, wait for every verdict, then let the pipeline settle.
    task automatic wait_results_done();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [cpca_pkg::CFG_IDX_W-1:0] index,
                                  logic [cpca_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == cpca_pkg::CFG_MIN_COUNT) min_count_reg = value;
        else if (index == cpca_pkg::CFG_MAX_COUNT) max_count_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(int lo, int hi);
        wait_results_done();
        write_register(cpca_pkg::CFG_MIN_COUNT, lo[cpca_pkg::CFG_W-1:0]);
        write_register(cpca_pkg::CFG_MAX_COUNT, hi[cpca_pkg::CFG_W-1:0]);
    endtask

    // Points on a circle at steadily rising or falling angles, which form a convex outline.
    task automatic make_convex_outline(int n, int radius, bit clockwise);
        real theta;
        real step_base;
        int  cx, cy;
        cx = int'($urandom_range(0, 65535 - 2 * radius)) - 32768 + radius;
        cy = int'($urandom_range(0, 65535 - 2 * radius)) - 32768 + radius;
        theta = $urandom_range(0, 6283) / 1000.0;
        step_base = TWO_PI / n;
        for (int i = 0; i < n; i++) begin
            add_point(cx + $rtoi(radius * $cos(theta)), cy + $rtoi(radius * $sin(theta)));
            theta += (clockwise ? -1.0 : 1.0) * step_base
                   * (0.3 + 0.7 * ($urandom_range(0, 1000) / 1000.0));
        end
    endtask

    function automatic int pick_corner_count();
        if ($urandom_range(0, 99) < 88) return $urandom_range(3, 9);
        return $urandom_range(10, 24);
    endfunction

    function automatic int pick_radius();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1000, 32767);
        return $urandom_range(1, 999);
    endfunction

    // Extreme coordinates and the basic shape cases under the reset limits.
    task automatic test_directed_shapes();
        // Full-range square, counterclockwise.
        add_point(-32768, -32768);
        add_point(32767, -32768);
        add_point(32767, 32767);
        add_point(-32768, 32767);
        send_outline();
        // Small square, clockwise.
        add_point(0, 0);
        add_point(0, 10);
        add_point(10, 10);
        add_point(10, 0);
        send_outline();
        // Concave dart.
        add_point(0, 0);
        add_point(100, 0);
        add_point(30, 30);
        add_point(0, 100);
        send_outline();
        // Three collinear vertices give a zero turn.
        add_point(0, 0);
        add_point(50, 0);
        add_point(100, 0);
        add_point(100, 100);
        send_outline();
        // A repeated vertex also gives a zero turn.
        add_point(5, 5);
        add_point(5, 5);
        add_point(20, 5);
        add_point(5, 20);
        send_outline();
        // A triangle is below the reset minimum of four.
        add_point(0, 0);
        add_point(10, 0);
        add_point(0, 10);
        send_outline();
        // A lone vertex can never be a polygon.
        add_point(-1, -1);
        send_outline();
    endtask

    // Count limits: above the maximum, exact limits, spare indexes, crossed limits, too few vertices.
    task automatic test_count_limits();
        make_convex_outline(8, 20000, 1'b0);
        send_outline();
        set_limits(3, 3);
        make_convex_outline(3, 30000, 1'b1);
        send_outline();
        // Writes to indexes without a register must change nothing.
        wait_results_done();
        write_register(CFG_SPARE_2, 8'hFF);
        write_register(CFG_SPARE_3, 8'h00);
        make_convex_outline(3, 30000, 1'b0);
        send_outline();
        set_limits(9, 4);
        make_convex_outline(4, 25000, 1'b0);
        send_outline();
        set_limits(3, 255);
        add_point(7, 7);
        add_point(-7, 9);
        send_outline();
    endtask

    // Squares wound many times: the vertex count saturates, and in the first the area too.
    task automatic test_long_polygon();
        set_limits(3, 255);
        for (int i = 0; i < 140; i++) begin
            add_point(-32768, -32768);
            add_point(32767, -32768);
            add_point(32767, 32767);
            add_point(-32768, 32767);
        end
        send_outline();
        set_limits(255, 255);
        for (int i = 0; i < 64; i++) begin
            add_point(0, 0);
            add_point(900, 0);
            add_point(900, 900);
            add_point(0, 900);
        end
        send_outline();
    endtask

    // The receiver holds off for a long stretch while vertices keep coming.
    task automatic test_receiver_holdoff();
        set_limits(3, 255);
        quiet_idle = 1'b1;
        hold_req   = 1'b1;
        for (int i = 0; i < 25; i++) begin
            make_convex_outline($urandom_range(3, 5), pick_radius(), $urandom_range(0, 1));
            send_outline();
        end
        quiet_idle = 1'b0;
        wait_results_done();
    endtask

    // Random polygons over several register settings, mostly convex outlines.
    task automatic test_random_polygons();
        int       kind;
        int       n;
        int       j;
        int       x0, y0, dx, dy;
        t_vertex  swap_v;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: set_limits(4, 7);
                1: set_limits(3, 255);
                2: set_limits(3, 3);
                3: set_limits(255, 255);
                4: set_limits(9, 4);
                5: set_limits(3, 8);
                6: set_limits(5, 24);
                default: begin
                    n = $urandom_range(3, 10);
                    set_limits(n, $urandom_range(n, 12));
                end
            endcase
            quiet_idle = (phase == 5);
            phase_vertices = 0;
            while (phase_vertices < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                n = pick_corner_count();
                if (kind < 72) begin
                    make_convex_outline(n, pick_radius(), $urandom_range(0, 1));
                    // Swapping two neighbors breaks an otherwise convex outline.
                    if (kind >= 60 && n >= 4) begin
                        j = $urandom_range(0, n - 2);
                        swap_v = outline[j];
                        outline[j] = outline[j + 1];
                        outline[j + 1] = swap_v;
                    end
                end else if (kind < 84) begin
                    for (int i = 0; i < n; i++)
                        add_point(int'($urandom_range(0, 65535)) - 32768,
                                  int'($urandom_range(0, 65535)) - 32768);
                end else if (kind < 92) begin
                    x0 = int'($urandom_range(0, 2000)) - 1000;
                    y0 = int'($urandom_range(0, 2000)) - 1000;
                    dx = int'($urandom_range(0, 100)) - 50;
                    dy = int'($urandom_range(0, 100)) - 50;
                    for (int i = 0; i < n; i++) add_point(x0 + i * dx, y0 + i * dy);
                end else begin
                    n = $urandom_range(1, 2);
                    for (int i = 0; i < n; i++)
                        add_point(int'($urandom_range(0, 65535)) - 32768,
                                  int'($urandom_range(0, 65535)) - 32768);
                end
                send_outline();
                // Now and then the sender waits for every verdict.
                if ($urandom_range(0, 19) == 0) wait_results_done();
            end
        end
        quiet_idle = 1'b0;
    endtask

    // Reset, then run each test in turn.
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_is_last   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        quiet_idle  = 1'b0;
        error_count = 0;
        phase_vertices = 0;
        clear_polygon();
        min_count_reg = cpca_pkg::MIN_COUNT_RESET;
        max_count_reg = cpca_pkg::MAX_COUNT_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_shapes();
        test_count_limits();
        test_long_polygon();
        test_receiver_holdoff();
        test_random_polygons();
        wait_results_done();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
